@@ hdl/fil_pkg.sv @@
// package for the fractional index lookup block
// holds the fixed field widths, the controller states and the command and status structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fil_pkg;

  // fixed field widths
  localparam int unsigned ValueW = 32;
  localparam int unsigned PosW   = 22;
  localparam int unsigned PosMax = 22'h3FFFFF;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 24;

  // tuser bit positions on the input side
  localparam int unsigned UserKindBit  = 0;
  localparam int unsigned UserFirstBit = 1;

  // item kinds
  localparam logic KindPoint  = 1'b0;
  localparam logic KindLookup = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_LAST,
    RES_DIV
  } res_sel_e;

  // controller to datapath
  typedef struct packed {
    logic     append;
    logic     load_key;
    logic     step;
    logic     div_start;
    logic     res_load;
    res_sel_e res_sel;
    logic     out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic count_zero;
    logic key_lt;
    logic idx_zero;
    logic idx_last;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ hdl/fractional_index_lookup_core.sv @@
// top level of the fractional index lookup block
// joins fil_ctrl and fil_dpath to the stream ports; uses fil_pkg
`timescale 1ns / 1ps
`default_nettype none

// Keeps a list of ascending signed Q16.16 breakpoints and answers lookup keys
// with their fractional position in that list (integer part above
// FRACTION_BITS fraction bits, saturated to 22 bits). A breakpoint beat
// (tuser kind 0) appends to the list, or restarts it when its first flag is
// set; breakpoints past MAX_POINTS are dropped. A lookup beat (tuser kind 1)
// is answered by one output beat. The lookup scans the stored points one per
// cycle through the single read port of the breakpoint memory and then runs
// a bit-serial divider for the fraction; a lookup that ends without a
// division skips the divider, and any lookup may wait for the output
// register. Input beats are taken one at a time; a finished result waits in
// the output register while the next beat is taken.
module fractional_index_lookup_core #(
  parameter int unsigned MAX_POINTS    = 64,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // value[31:0]
  input  wire logic [fil_pkg::InDataW-1:0]    s_axis_tdata_i,
  // kind[0], first[1]
  input  wire logic [fil_pkg::InUserW-1:0]    s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // position[21:0], zero fill[23:22]
  output logic      [fil_pkg::OutDataW-1:0]   m_axis_tdata_o
);

  fil_pkg::cmd_t            cmd;
  fil_pkg::sts_t            sts;
  logic [fil_pkg::PosW-1:0] position;

  // controller
  fil_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_kind_i (s_axis_tuser_i[fil_pkg::UserKindBit]),
    .in_ready_o(s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // datapath
  fil_dpath #(
    .MAX_POINTS   (MAX_POINTS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .value_i    (s_axis_tdata_i[fil_pkg::ValueW-1:0]),
    .first_i    (s_axis_tuser_i[fil_pkg::UserFirstBit]),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .position_o (position)
  );

  // pad the position to whole bytes
  assign m_axis_tdata_o = fil_pkg::OutDataW'(position);

endmodule

`default_nettype wire

@@ hdl/fil_div.sv @@
// bit-serial restoring divider for the fraction of a lookup
// gives floor(above * 2^FRACTION_BITS / total) for above < total, one bit per cycle
// uses fil_pkg for the operand width
`timescale 1ns / 1ps
`default_nettype none

module fil_div #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [fil_pkg::ValueW-1:0]       above_i,
  input  wire logic [fil_pkg::ValueW-1:0]       total_i,
  output logic                                  done_o,
  output logic      [FRACTION_BITS-1:0]         quot_o
);

  localparam int unsigned CntW = $clog2(FRACTION_BITS + 1);

  logic [fil_pkg::ValueW-1:0] rem_q, rem_d;
  logic [fil_pkg::ValueW-1:0] tot_q, tot_d;
  logic [FRACTION_BITS-1:0]   quot_q, quot_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;

  logic [fil_pkg::ValueW:0]   shifted;
  logic [fil_pkg::ValueW-1:0] diff;
  logic                       ge;

  // one restoring step, the remainder stays below the divisor
  assign shifted = {rem_q, 1'b0};
  assign diff    = shifted[fil_pkg::ValueW-1:0] - tot_q;
  assign ge      = shifted >= {1'b0, tot_q};

  always_comb begin
    rem_d  = rem_q;
    tot_d  = tot_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      rem_d  = above_i;
      tot_d  = total_i;
      quot_d = '0;
      cnt_d  = CntW'(FRACTION_BITS);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      rem_d  = ge ? diff : shifted[fil_pkg::ValueW-1:0];
      quot_d = {quot_q[FRACTION_BITS-2:0], ge};
      cnt_d  = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand and quotient registers
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    tot_q  <= tot_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

@@ hdl/fil_dpath.sv @@
// datapath of the fractional index lookup: breakpoint memory, scan registers,
// result and output registers; instantiates fil_div and uses fil_pkg
`timescale 1ns / 1ps
`default_nettype none

module fil_dpath #(
  parameter int unsigned MAX_POINTS    = 64,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire fil_pkg::cmd_t               cmd_i,
  output fil_pkg::sts_t                    sts_o,
  input  wire logic [fil_pkg::ValueW-1:0]  value_i,
  input  wire logic                        first_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [fil_pkg::PosW-1:0]    position_o
);

  localparam int unsigned IdxW = $clog2(MAX_POINTS);
  localparam int unsigned CntW = $clog2(MAX_POINTS + 1);
  localparam int unsigned SumW = CntW + FRACTION_BITS;
  localparam int unsigned WideW = (SumW > fil_pkg::PosW) ? SumW : fil_pkg::PosW;

  logic [fil_pkg::ValueW-1:0] mem [MAX_POINTS];

  logic [CntW-1:0]                  count_q, count_d;
  logic [IdxW-1:0]                  scan_idx_q, scan_idx_d;
  logic signed [fil_pkg::ValueW-1:0] key_q;
  logic signed [fil_pkg::ValueW-1:0] lo_q;
  logic signed [fil_pkg::ValueW-1:0] rdata_q;
  logic [fil_pkg::PosW-1:0]         res_q, res_d;
  logic                             out_valid_q;
  logic [fil_pkg::PosW-1:0]         out_q;

  logic                             wr_en;
  logic [IdxW-1:0]                  wr_addr;
  logic [fil_pkg::ValueW-1:0]       above_w, total_w;
  logic                             div_done;
  logic [FRACTION_BITS-1:0]         quot;
  logic [CntW-1:0]                  int_part;
  logic [FRACTION_BITS-1:0]         frac_part;
  logic [WideW-1:0]                 full_w;

  // append address and new fill count
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_q[IdxW-1:0];
    count_d = count_q;
    if (cmd_i.append) begin
      if (first_i) begin
        wr_en   = 1'b1;
        wr_addr = '0;
        count_d = CntW'(1);
      end else if (count_q < CntW'(MAX_POINTS)) begin
        wr_en   = 1'b1;
        count_d = count_q + CntW'(1);
      end
    end
  end

  // scan index, also the read address of the next cycle
  always_comb begin
    scan_idx_d = scan_idx_q;
    if (cmd_i.load_key) begin
      scan_idx_d = '0;
    end else if (cmd_i.step) begin
      scan_idx_d = scan_idx_q + IdxW'(1);
    end
  end

  // breakpoint memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= value_i;
    end
    rdata_q <= mem[scan_idx_d];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      scan_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      scan_idx_q <= scan_idx_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // divider operands: distance above the lower point and segment length,
  // both non-negative and below 2^32 since lo <= key < hi
  assign above_w = key_q - lo_q;
  assign total_w = rdata_q - lo_q;

  fil_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .above_i(above_w),
    .total_i(total_w),
    .done_o (div_done),
    .quot_o (quot)
  );

  // result assembly with saturation to the position width
  always_comb begin
    int_part  = '0;
    frac_part = '0;
    unique case (cmd_i.res_sel)
      fil_pkg::RES_ZERO: begin
        int_part  = '0;
        frac_part = '0;
      end
      fil_pkg::RES_LAST: begin
        int_part  = count_q - CntW'(1);
      end
      fil_pkg::RES_DIV: begin
        int_part  = CntW'(scan_idx_q) - CntW'(1);
        frac_part = quot;
      end
      default: begin
        int_part  = '0;
        frac_part = '0;
      end
    endcase
    full_w = WideW'({int_part, frac_part});
    if (full_w > WideW'(fil_pkg::PosMax)) begin
      res_d = fil_pkg::PosW'(fil_pkg::PosMax);
    end else begin
      res_d = full_w[fil_pkg::PosW-1:0];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_key) begin
      key_q <= value_i;
    end
    if (cmd_i.step) begin
      lo_q <= rdata_q;
    end
    if (cmd_i.res_load) begin
      res_q <= res_d;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  // status to the controller
  always_comb begin
    sts_o.count_zero = (count_q == '0);
    sts_o.key_lt     = (key_q < rdata_q);
    sts_o.idx_zero   = (scan_idx_q == '0);
    sts_o.idx_last   = (CntW'(scan_idx_q) == count_q - CntW'(1));
    sts_o.div_done   = div_done;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign position_o  = out_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_POINTS))
    else $error("fill count above store depth");

  a_step_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (CntW'(scan_idx_q) + CntW'(1) < count_q))
    else $error("scan stepped past the stored list");

  a_div_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.res_load && cmd_i.res_sel == fil_pkg::RES_DIV) |-> div_done)
    else $error("quotient taken before divider finished");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while full");

endmodule

`default_nettype wire

@@ hdl/fil_ctrl.sv @@
// controller state machine of the fractional index lookup
// sequences append, scan, divide and result hand-off; uses fil_pkg
`timescale 1ns / 1ps
`default_nettype none

module fil_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_kind_i,
  output logic               in_ready_o,
  input  wire fil_pkg::sts_t sts_i,
  output fil_pkg::cmd_t      cmd_o
);

  fil_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fil_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.res_sel = fil_pkg::RES_ZERO;
    in_ready_o    = 1'b0;
    unique case (state_q)
      fil_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_kind_i == fil_pkg::KindPoint) begin
            cmd_o.append = 1'b1;
          end else begin
            cmd_o.load_key = 1'b1;
            if (sts_i.count_zero) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_sel  = fil_pkg::RES_ZERO;
              state_d        = fil_pkg::ST_DONE;
            end else begin
              state_d = fil_pkg::ST_SCAN;
            end
          end
        end
      end
      fil_pkg::ST_SCAN: begin
        priority if (sts_i.key_lt && sts_i.idx_zero) begin
          // key below the first point
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = fil_pkg::RES_ZERO;
          state_d        = fil_pkg::ST_DONE;
        end else if (sts_i.key_lt) begin
          cmd_o.div_start = 1'b1;
          state_d         = fil_pkg::ST_DIV;
        end else if (sts_i.idx_last) begin
          // key at or above the last point
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = fil_pkg::RES_LAST;
          state_d        = fil_pkg::ST_DONE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      fil_pkg::ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = fil_pkg::RES_DIV;
          state_d        = fil_pkg::ST_DONE;
        end
      end
      fil_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = fil_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fil_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ test/tb.sv @@
// testbench for fractional_index_lookup_core: directed and random breakpoint and lookup beats
// a scoreboard class predicts each position, which is checked against the output stream
// depends on fil_pkg and fractional_index_lookup_core
`timescale 1ns / 1ps
`default_nettype none

// predicts lookup positions from its own copy of the breakpoint list
class lookup_scoreboard;
  localparam int unsigned Depth = 64;
  localparam int unsigned FracBits = 16;

  logic signed [31:0] points[Depth];
  int unsigned        point_total;
  logic [21:0]        position_q[$];
  int unsigned        fails;
  int unsigned        reported;

  function new();
    point_total = 0;
    fails = 0;
    reported = 0;
  endfunction

  // fractional position of a key in the stored list
  function logic [21:0] locate(logic signed [31:0] key);
    longint lo, hi, above, total, frac, pos;
    if (point_total == 0 || key < points[0]) begin
      return '0;
    end
    for (int i = 1; i < point_total; i++) begin
      if (key < points[i]) begin
        lo = longint'(points[i-1]);
        hi = longint'(points[i]);
        total = hi - lo;
        above = longint'(key) - lo;
        frac = (above << FracBits) / total;
        pos = (longint'(i - 1) << FracBits) + frac;
        return (pos > fil_pkg::PosMax) ? 22'(fil_pkg::PosMax) : pos[21:0];
      end
    end
    pos = longint'(point_total - 1) << FracBits;
    return (pos > fil_pkg::PosMax) ? 22'(fil_pkg::PosMax) : pos[21:0];
  endfunction

  // an accepted input beat: update the list or queue the expected position
  function void note_item(logic kind, logic [31:0] value, logic first);
    if (kind == fil_pkg::KindPoint) begin
      if (first) point_total = 0;
      if (point_total < Depth) begin
        points[point_total] = value;
        point_total++;
      end
    end else begin
      position_q.push_back(locate(value));
    end
  endfunction

  // an accepted output beat
  function void check_position(logic [21:0] got);
    logic [21:0] want;
    if (position_q.size() == 0) begin
      fails++;
      if (reported < 10) begin
        reported++;
        $display("unexpected output beat: position %h", got);
      end
      return;
    end
    want = position_q.pop_front();
    if (got !== want) begin
      fails++;
      if (reported < 10) begin
        reported++;
        $display("position mismatch: expected %h, got %h", want, got);
      end
    end
  endfunction

  function int unsigned pending();
    return position_q.size();
  endfunction

  // expected positions that never came out count as failures
  function void close();
    if (position_q.size() != 0) begin
      $display("%0d expected positions never came out", position_q.size());
      fails += position_q.size();
    end
  endfunction
endclass

module tb;
  localparam int unsigned MaxPoints = 64;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned Items     = 550;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [fil_pkg::InDataW-1:0]   s_tdata;
  logic [fil_pkg::InUserW-1:0]   s_tuser;
  logic                          m_tvalid;
  logic                          m_tready;
  logic [fil_pkg::OutDataW-1:0]  m_tdata;
  logic                          calm;

  lookup_scoreboard sb;

  fractional_index_lookup_core #(
    .MAX_POINTS   (MaxPoints),
    .FRACTION_BITS(FracBits)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  // clock, 8 ns period
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // known input values from time zero
  initial begin
    rst_ni   = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    m_tready = 1'b0;
    calm     = 1'b0;
    sb       = new();
  end

  // output side back-pressure
  always @(negedge clk_i) begin
    m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 9);
  end

  // check every accepted output beat
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      sb.check_position(m_tdata[fil_pkg::PosW-1:0]);
    end
  end

  // overall time limit
  initial begin
    #5000000;
    $display("tb NOT OK");
    $finish;
  end

  // present one beat after a random gap and wait until it is taken
  task automatic push_item(input logic kind, input logic [31:0] value, input logic first);
    logic [fil_pkg::InUserW-1:0] user;
    user = '0;
    user[fil_pkg::UserKindBit]  = kind;
    user[fil_pkg::UserFirstBit] = first;
    while (!calm && $urandom_range(0, 99) < 9) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= user;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sb.note_item(kind, value, first);
    @(negedge clk_i);
  endtask

  // clip a wide value into the signed 32-bit range
  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sh7FFFFFFF) return 32'h7FFFFFFF;
    if (v < -64'sh80000000) return 32'h80000000;
    return v[31:0];
  endfunction

  initial begin
    int     sent, seq, n, m, k, j, r, mode, guard, idx;
    int     pts[$];
    int     v;
    longint acc, gap;
    logic [31:0] key;

    sent = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty list, first flag on a lookup is ignored
    push_item(fil_pkg::KindLookup, 32'h0000_0000, 1'b1);
    push_item(fil_pkg::KindLookup, 32'h8000_0000, 1'b0);
    // single point at the most negative value
    push_item(fil_pkg::KindPoint, 32'h8000_0000, 1'b1);
    push_item(fil_pkg::KindLookup, 32'h8000_0000, 1'b0);
    push_item(fil_pkg::KindLookup, 32'h7FFF_FFFF, 1'b0);
    // widest possible segment
    push_item(fil_pkg::KindPoint, 32'h7FFF_FFFF, 1'b0);
    push_item(fil_pkg::KindLookup, 32'h0000_0000, 1'b0);
    push_item(fil_pkg::KindLookup, 32'h7FFF_FFFE, 1'b0);
    push_item(fil_pkg::KindLookup, 32'h7FFF_FFFF, 1'b0);
    push_item(fil_pkg::KindLookup, 32'hFFFF_FFFF, 1'b1);
    // restart with a list that is not ascending
    push_item(fil_pkg::KindPoint, 32'h0001_0000, 1'b1);
    push_item(fil_pkg::KindPoint, 32'h0003_0000, 1'b0);
    push_item(fil_pkg::KindPoint, 32'h0002_0000, 1'b0);
    push_item(fil_pkg::KindPoint, 32'h0005_0000, 1'b0);
    push_item(fil_pkg::KindLookup, 32'h0000_8000, 1'b0);
    push_item(fil_pkg::KindLookup, 32'h0001_0000, 1'b0);
    push_item(fil_pkg::KindLookup, 32'h0002_8000, 1'b0);
    push_item(fil_pkg::KindLookup, 32'h0004_ffff, 1'b0);
    push_item(fil_pkg::KindLookup, 32'h0006_0000, 1'b0);
    // segment of width one
    push_item(fil_pkg::KindPoint, 32'hFFFF_FFFF, 1'b1);
    push_item(fil_pkg::KindPoint, 32'h0000_0000, 1'b0);
    push_item(fil_pkg::KindLookup, 32'hFFFF_FFFF, 1'b0);
    push_item(fil_pkg::KindLookup, 32'h0000_0000, 1'b0);

    // random part: mostly whole lists followed by lookups, some noise
    seq = 0;
    while (sent < Items) begin
      calm = (sent >= 150 && sent < 300);
      r = $urandom_range(0, 99);
      if (r < 85) begin
        // choose list length, mostly short, sometimes past the store depth
        r = $urandom_range(0, 99);
        if (seq == 2 || r >= 93) n = $urandom_range(60, 72);
        else if (r >= 75) n = $urandom_range(9, 40);
        else n = $urandom_range(1, 8);
        mode = $urandom_range(0, 9);
        pts.delete();
        if (mode < 4) begin
          // sorted full-range values
          for (k = 0; k < n; k++) begin
            v = int'($urandom);
            idx = 0;
            while (idx < pts.size() && pts[idx] <= v) idx++;
            pts.insert(idx, v);
          end
        end else if (mode < 9) begin
          // small ascending steps, duplicates allowed
          acc = longint'(int'($urandom));
          for (k = 0; k < n; k++) begin
            pts.push_back(int'(sat32(acc)));
            acc = acc + (($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 32'h3_0000));
          end
        end else begin
          // unordered values in a narrow range
          acc = longint'(int'($urandom));
          for (k = 0; k < n; k++) begin
            pts.push_back(int'(sat32(acc + $urandom_range(0, 32'h4_0000))));
          end
        end
        for (k = 0; k < n; k++) begin
          push_item(fil_pkg::KindPoint, pts[k],
                    (k == 0) ? ($urandom_range(0, 9) != 0) : 1'b0);
          if (k < MaxPoints) sent++;
        end
        // lookups aimed at the list
        m = $urandom_range(1, 6);
        for (k = 0; k < m; k++) begin
          j = $urandom_range(0, pts.size() - 1);
          case ($urandom_range(0, 5))
            0: key = pts[j];
            1: begin
              if (j + 1 < pts.size()) gap = longint'(pts[j+1]) - longint'(pts[j]);
              else gap = 0;
              if (gap > 0) key = sat32(longint'(pts[j]) + (longint'($urandom) % gap));
              else key = pts[j];
            end
            2: key = sat32(longint'(pts[0]) - 1 - $urandom_range(0, 32'h1_0000));
            3: key = sat32(longint'(pts[pts.size()-1]) + $urandom_range(0, 32'h1_0000));
            4: key = $urandom;
            default: key = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
          endcase
          push_item(fil_pkg::KindLookup, key, 1'($urandom_range(0, 1)));
          sent++;
        end
        seq++;
      end else begin
        // single random beat
        push_item(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
        sent++;
      end
    end
    calm = 1'b0;
    s_tvalid <= 1'b0;

    // drain outstanding results, then allow for a full lookup
    guard = 0;
    while (sb.pending() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (120) @(posedge clk_i);
    sb.close();
    if (sb.fails == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
